// ===== hdl/afpc_pkg.sv =====
// ----------------------------------------------------------------------------
// afpc_pkg: shared constants and types for the allele fraction classifier.
// Holds the register codes, class codes, beat layouts and the pattern table.
// ----------------------------------------------------------------------------
package afpc_pkg;

  localparam int MaxPaths         = 8;
  localparam int CountBits        = 24;
  localparam int TotalBits        = 27;
  localparam int TolBits          = 16;
  localparam int CfgIdxBits       = 1;
  localparam int CfgDataBits      = 27;
  localparam int PatLen           = 5;
  localparam int NumPatterns      = 6;

  localparam logic [CfgIdxBits-1:0] RegMinTotal = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegTol      = 1'd1;

  typedef enum logic [2:0] {
    ClsUnknown  = 3'd0,
    ClsHom      = 3'd1,
    ClsHet      = 3'd2,
    ClsTri      = 3'd3,
    ClsBranch   = 3'd4,
    ClsBranch2  = 3'd5,
    ClsNoisy    = 3'd6
  } class_t;

  typedef struct packed {
    logic [2:0] len;
    logic [5:0] k0;
    logic [5:0] k1;
    logic [5:0] k2;
    logic [5:0] k3;
    logic [5:0] k4;
    class_t     cls;
    logic [1:0] dep;
  } pattern_t;

  // entries in units of 1/48, in priority order
  function automatic pattern_t pattern(input int p);
    pattern_t r;
    begin
      unique case (p)
        0:       r = '{3'd5, 6'd24, 6'd12, 6'd6,  6'd3, 6'd3, ClsBranch2, 2'd3};
        1:       r = '{3'd4, 6'd24, 6'd12, 6'd6,  6'd6, 6'd0, ClsBranch2, 2'd2};
        2:       r = '{3'd3, 6'd24, 6'd12, 6'd12, 6'd0, 6'd0, ClsBranch,  2'd1};
        3:       r = '{3'd3, 6'd16, 6'd16, 6'd16, 6'd0, 6'd0, ClsTri,     2'd0};
        4:       r = '{3'd2, 6'd24, 6'd24, 6'd0,  6'd0, 6'd0, ClsHet,     2'd0};
        default: r = '{3'd1, 6'd48, 6'd0,  6'd0,  6'd0, 6'd0, ClsHom,     2'd0};
      endcase
      return r;
    end
  endfunction

  function automatic logic [5:0] pat_k(input pattern_t pt, input int i);
    begin
      unique case (i)
        0:       return pt.k0;
        1:       return pt.k1;
        2:       return pt.k2;
        3:       return pt.k3;
        default: return pt.k4;
      endcase
    end
  endfunction

  typedef struct packed {
    class_t     cls;
    logic [1:0] dep;
  } match_t;

  typedef struct packed {
    logic [3:0]                         path_count;
    logic [MaxPaths-1:0][CountBits-1:0] reads;
  } in_beat_t;

  typedef struct packed {
    class_t               class_code;
    logic [1:0]           depth;
    logic [2:0]           parent_index;
    logic                 parent_valid;
    logic [TotalBits-1:0] read_total;
  } out_beat_t;

endpackage

// ===== hdl/afpc_stream_if.sv =====
// ----------------------------------------------------------------------------
// afpc_stream_if: valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface afpc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/afpc_lane.sv =====
// ----------------------------------------------------------------------------
// afpc_lane: tolerance test of one sorted count against all pattern entries.
// One registered 3145728*c - 65536*k*T comparison set per pattern.
// ----------------------------------------------------------------------------
module afpc_lane #(
  parameter int LANE = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [afpc_pkg::CountBits-1:0]   count,
  input  logic [afpc_pkg::TotalBits+5-1:0] total,
  input  logic [afpc_pkg::TolBits-1:0]     tol,
  output logic [afpc_pkg::NumPatterns-1:0] ok
);
  import afpc_pkg::*;

  // total is up to MAX_PATHS*2^COUNT_BITS; k*65536*T fits in 6+16+32 bits
  localparam int TB = TotalBits + 5;
  localparam int W  = TB + 6 + 16 + 1;

  logic [W-1:0] a;
  logic [W-1:0] lim;
  logic [NumPatterns-1:0] ok_next;

  always_comb begin
    logic [W-1:0] b;
    logic [W-1:0] d;
    a   = W'(count) << 20;
    a   = a + (W'(count) << 21);
    lim = W'(tol) * W'(total) * W'(48);
    for (int p = 0; p < NumPatterns; p++) begin
      b = (W'(pat_k(pattern(p), LANE)) * W'(total)) << 16;
      d = (a > b) ? a - b : b - a;
      ok_next[p] = (d <= lim);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok <= ok_next;
    end
  end
endmodule

// ===== hdl/afpc_merge.sv =====
// ----------------------------------------------------------------------------
// afpc_merge: combine the lane results in priority order into one class.
// ----------------------------------------------------------------------------
module afpc_merge (
  input  logic [afpc_pkg::PatLen-1:0][afpc_pkg::NumPatterns-1:0] lane_ok,
  input  logic [3:0]                                            n,
  output afpc_pkg::match_t                                      match
);
  import afpc_pkg::*;

  always_comb begin
    logic hit;
    logic ok;
    pattern_t pt;
    hit   = 1'b0;
    match = '{ClsNoisy, 2'd0};
    for (int p = 0; p < NumPatterns; p++) begin
      pt = pattern(p);
      ok = (n == 4'(pt.len));
      for (int i = 0; i < PatLen; i++) begin
        if (i < int'(pt.len)) ok = ok & lane_ok[i][p];
      end
      if (ok && !hit) begin
        hit   = 1'b1;
        match = '{pt.cls, pt.dep};
      end
    end
  end
endmodule

// ===== hdl/allele_fraction_pattern_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// allele_fraction_pattern_classifier_unit: bubble allele fraction classifier.
// Sum, rank sort, five tolerance lanes, priority merge, output register.
//
//  channel | dir | payload
//  in_ch   | in  | path_count, reads[0..7]
//  out_ch  | out | class_code, depth, parent_index, parent_valid, read_total
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// One bubble per cycle, back to back while the pipe advances; three register stages
// (sum/sort, lane compare, output).
// The whole pipe advances when the output register is empty or being drained;
// a held result drops in_ch.ready in the same cycle.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module allele_fraction_pattern_classifier_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [afpc_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [afpc_pkg::CfgDataBits-1:0] cfg_data,
  afpc_stream_if.sink                      in_ch,
  afpc_stream_if.source                    out_ch
);
  import afpc_pkg::*;

  localparam int IB = $clog2(MaxPaths);
  localparam int TB = TotalBits + 5;

  logic [TotalBits-1:0] min_reads;
  logic [TolBits-1:0]   fraction_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_reads          <= TotalBits'(10);
      fraction_tolerance <= TolBits'(3277);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegMinTotal: min_reads          <= cfg_data[TotalBits-1:0];
        RegTol:      fraction_tolerance <= cfg_data[TolBits-1:0];
        default:     ;
      endcase
    end
  end

  logic adv;
  logic v1, v2;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: clamp, mask, sum, rank sort, parent search
  logic [3:0]                         n0;
  logic [MaxPaths-1:0][CountBits-1:0] cnt0;
  logic [MaxPaths-1:0][IB-1:0]        rank0;
  logic [PatLen-1:0][CountBits-1:0]   srt0;
  logic [TB-1:0]                      tot0;
  logic [IB-1:0]                      par0;

  always_comb begin
    n0 = (in_ch.data.path_count > 4'(MaxPaths)) ? 4'(MaxPaths)
                                                 : in_ch.data.path_count;
    tot0 = '0;
    for (int i = 0; i < MaxPaths; i++) begin
      cnt0[i] = (i < int'(n0)) ? in_ch.data.reads[i] : '0;
      tot0    = tot0 + TB'(cnt0[i]);
    end
    // rank = lanes ahead: larger counts, or equal counts at a lower index
    for (int i = 0; i < MaxPaths; i++) begin
      rank0[i] = '0;
      for (int j = 0; j < MaxPaths; j++) begin
        if ((cnt0[j] > cnt0[i]) || ((cnt0[j] == cnt0[i]) && (j < i))) begin
          rank0[i] = rank0[i] + IB'(1);
        end
      end
    end
    // ranks are a permutation; rank 0 is the lowest index of the largest count
    srt0 = '0;
    par0 = '0;
    for (int i = 0; i < MaxPaths; i++) begin
      for (int r = 0; r < PatLen; r++) begin
        if (rank0[i] == IB'(r)) srt0[r] = cnt0[i];
      end
      if (rank0[i] == '0) par0 = IB'(i);
    end
  end

  logic [3:0]                       n1;
  logic [PatLen-1:0][CountBits-1:0] srt1;
  logic [TB-1:0]                    tot1;
  logic [IB-1:0]                    par1;
  logic                             go1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
    end
    if (adv) begin
      n1   <= n0;
      srt1 <= srt0;
      tot1 <= tot0;
      par1 <= par0;
      go1  <= (tot0 != '0) && (tot0 >= TB'(min_reads));
    end
  end

  // stage 2: lanes, registered alongside the stage 2 fields
  logic [PatLen-1:0][NumPatterns-1:0] lane_ok;
  for (genvar g = 0; g < PatLen; g++) begin : g_lane
    afpc_lane #(.LANE(g)) u_lane (
      .clk   (clk),
      .en    (adv),
      .count (srt1[g]),
      .total (tot1),
      .tol   (fraction_tolerance),
      .ok    (lane_ok[g])
    );
  end

  logic [3:0]    n2;
  logic [TB-1:0] tot2;
  logic [IB-1:0] par2;
  logic          go2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      n2     <= n1;
      tot2   <= tot1;
      par2   <= par1;
      go2    <= go1;
    end
  end

  match_t m2;
  afpc_merge u_merge (
    .lane_ok (lane_ok),
    .n       (n2),
    .match   (m2)
  );

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= v2;
    end
    if (adv) begin
      out_ch.data.read_total <= tot2[TotalBits-1:0];
      if (!go2) begin
        out_ch.data.class_code   <= ClsUnknown;
        out_ch.data.depth        <= 2'd0;
        out_ch.data.parent_index <= 3'd0;
        out_ch.data.parent_valid <= 1'b0;
      end else begin
        out_ch.data.class_code <= m2.cls;
        out_ch.data.depth      <= m2.dep;
        if (m2.cls == ClsBranch || m2.cls == ClsBranch2) begin
          out_ch.data.parent_index <= 3'(par2);
          out_ch.data.parent_valid <= 1'b1;
        end else begin
          out_ch.data.parent_index <= 3'd0;
          out_ch.data.parent_valid <= 1'b0;
        end
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_pval: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.data.parent_valid ==
      (out_ch.data.class_code == ClsBranch || out_ch.data.class_code == ClsBranch2))
    else $error("parent_valid inconsistent with class");
  a_unk: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.read_total == '0 |-> out_ch.data.class_code == ClsUnknown)
    else $error("zero total not unknown");
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: allele fraction pattern classifier testbench.
// Directed table then phased random bubbles under several register settings.
// Every output beat is checked field by field against its directed row or a local classifier.
// ----------------------------------------------------------------------------
module tb;
  import afpc_pkg::*;

  localparam int NPaths   = MaxPaths;
  localparam int CntBits  = CountBits;
  localparam int MaxCycle = 200000;
  localparam int DrainCyc = 10;

  typedef in_beat_t  bubble_t;
  typedef out_beat_t verdict_t;

  typedef logic [CntBits-1:0] counts_t [NPaths];

  typedef struct {
    bubble_t  bub;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_index;
  logic [CfgDataBits-1:0] cfg_data;

  afpc_stream_if #(.payload_t(bubble_t))  in_ch ();
  afpc_stream_if #(.payload_t(verdict_t)) out_ch ();

  allele_fraction_pattern_classifier_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // shadow registers
  logic [TotalBits-1:0] min_reads_q;
  logic [TolBits-1:0]   tol_q;

  verdict_t verdict_q[$];
  dir_row_t dir_rows[$];
  int       n_fail;
  int       n_mism;
  int       n_sent;
  int       n_seen;
  int       cls_hist[8];
  int       cycles;
  bit       hold_req;
  bit       hold_taken;
  int       hold_left;
  int       stall_mode;

  // canonical patterns, entries in 48ths, priority order
  int     pat_len[6]   = '{5, 4, 3, 3, 2, 1};
  int     pat_num[6][5] = '{'{24, 12, 6, 3, 3}, '{24, 12, 6, 6, 0}, '{24, 12, 12, 0, 0},
                           '{16, 16, 16, 0, 0}, '{24, 24, 0, 0, 0}, '{48, 0, 0, 0, 0}};
  class_t pat_cls[6]   = '{ClsBranch2, ClsBranch2, ClsBranch, ClsTri, ClsHet, ClsHom};
  int     pat_dep[6]   = '{3, 2, 1, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = 1'b1;
      #4 clk = 1'b0;
    end
  end

  function automatic counts_t unpack_counts(bubble_t b);
    counts_t c;
    for (int i = 0; i < NPaths; i++) c[i] = b.reads[i];
    return c;
  endfunction

  function automatic bubble_t pack_bubble(logic [3:0] pc, counts_t c);
    bubble_t b;
    b            = '0;
    b.path_count = pc;
    for (int i = 0; i < NPaths; i++) b.reads[i] = c[i];
    return b;
  endfunction

  function automatic verdict_t classify(bubble_t b);
    counts_t          c;
    longint unsigned  srt[NPaths];
    longint unsigned  total;
    longint unsigned  a;
    longint unsigned  r;
    longint unsigned  d;
    longint unsigned  v;
    int               n;
    int               best;
    bit               ok;
    verdict_t         o;
    c     = unpack_counts(b);
    n     = (b.path_count > NPaths) ? NPaths : int'(b.path_count);
    total = 0;
    o     = '0;
    o.class_code = ClsUnknown;
    for (int i = 0; i < n; i++) begin
      total  += c[i];
      srt[i] = c[i];
    end
    o.read_total = total[TotalBits-1:0];
    if (total != 0 && total >= min_reads_q) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n - 1 - i; j++)
          if (srt[j] < srt[j+1]) begin
            v = srt[j]; srt[j] = srt[j+1]; srt[j+1] = v;
          end
      o.class_code = ClsNoisy;
      for (int p = 0; p < 6; p++) begin
        ok = (pat_len[p] == n);
        for (int i = 0; ok && i < n && i < 5; i++) begin
          a  = srt[i] * 64'd3145728;
          r  = longint'(pat_num[p][i]) * 64'd65536 * total;
          d  = (a > r) ? a - r : r - a;
          ok = d <= longint'(tol_q) * 64'd48 * total;
        end
        if (ok) begin
          o.class_code = pat_cls[p];
          o.depth      = 2'(pat_dep[p]);
          break;
        end
      end
      if (o.class_code == ClsBranch || o.class_code == ClsBranch2) begin
        best = 0;
        for (int i = 1; i < n; i++)
          if (c[i] > c[best]) best = i;
        o.parent_index = 3'(best);
        o.parent_valid = 1'b1;
      end
    end
    return o;
  endfunction

  task automatic add_row(input logic [3:0] pc, input int c0, input int c1, input int c2,
                         input int c3, input int c4, input int c5, input int c6,
                         input int c7, input bit typed, input class_t cls,
                         input int total);
    dir_row_t row;
    counts_t  c;
    c = '{CntBits'(c0), CntBits'(c1), CntBits'(c2), CntBits'(c3),
          CntBits'(c4), CntBits'(c5), CntBits'(c6), CntBits'(c7)};
    row.bub   = pack_bubble(pc, c);
    row.typed = typed;
    row.want  = '0;
    row.want.class_code = cls;
    row.want.read_total = TotalBits'(total);
    dir_rows.push_back(row);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataBits'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == RegMinTotal) min_reads_q = TotalBits'(val);
    else tol_q = TolBits'(val);
  endtask

  task automatic drain();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCyc) @(posedge clk);
  endtask

  // one beat into the block; burst gaps are handled by the caller
  task automatic send(input bubble_t b, input bit typed, input verdict_t want);
    @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    verdict_q.push_back(typed ? want : classify(b));
    n_sent++;
    if (n_sent == 350) hold_req = 1'b1;
  endtask

  task automatic gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    if (g != 0) begin
      @(posedge clk);
      in_ch.valid <= 1'b0;
      repeat (g - 1) @(posedge clk);
    end
  endtask

  function automatic bubble_t rand_bubble();
    counts_t c;
    int      p;
    int      n;
    int      m;
    int      j;
    int      v;
    int      sel;
    logic [CntBits-1:0] t;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < NPaths; i++) c[i] = CntBits'($urandom());
    if (sel < 7) begin
      // well-formed pattern with jitter and shuffled order
      p = $urandom_range(0, 5);
      n = pat_len[p];
      m = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 310000) : $urandom_range(1, 60);
      for (int i = 0; i < n; i++) begin
        v = pat_num[p][i] * m;
        if ($urandom_range(0, 1)) v = v + $urandom_range(0, v / 10 + 1);
        else if (v > 0) v = v - $urandom_range(0, v / 10);
        c[i] = CntBits'(v);
      end
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = c[i]; c[i] = c[j]; c[j] = t;
      end
      return pack_bubble(4'(n), c);
    end
    if (sel == 7)
      for (int i = 0; i < NPaths; i++) c[i] = CntBits'($urandom_range(0, 40));
    return pack_bubble(4'($urandom_range(0, 15)), c);
  endfunction

  task automatic random_phase(input int count);
    for (int k = 0; k < count; k++) begin
      send(rand_bubble(), 1'b0, '0);
      if ($urandom_range(0, 4) == 0) gap();
    end
    @(posedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_req && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 3) != 0;
        2:       out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (cycles % 5) < 2;
      endcase
    end
  end

  // ready and valid are settled at the falling edge; the beat lands on the next rise
  always @(negedge clk) begin
    verdict_t exp_v;
    verdict_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      n_seen++;
      cls_hist[got.class_code]++;
      if (verdict_q.size() == 0) begin
        n_fail++;
        $display("unexpected beat %p", got);
      end else begin
        exp_v = verdict_q.pop_front();
        if (got !== exp_v) begin
          n_fail++;
          n_mism++;
          if (n_mism <= 10) begin
            $display("mismatch: exp cls=%0d dep=%0d par=%0d pv=%0d tot=%0d",
                     exp_v.class_code, exp_v.depth, exp_v.parent_index,
                     exp_v.parent_valid, exp_v.read_total);
            $display("          got cls=%0d dep=%0d par=%0d pv=%0d tot=%0d",
                     got.class_code, got.depth, got.parent_index,
                     got.parent_valid, got.read_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= MaxCycle) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = RegMinTotal;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    min_reads_q  = 10;
    tol_q        = 3277;
    n_fail = 0; n_mism = 0; n_sent = 0; n_seen = 0;
    cycles = 0; hold_req = 0; hold_taken = 0; hold_left = 0; stall_mode = 0;
    foreach (cls_hist[i]) cls_hist[i] = 0;

    // zero paths, zero total, below and at the read floor, extremes, clamped count
    add_row(0, 'hFFFFFF, 5, 5, 5, 5, 5, 5, 5, 1, ClsUnknown, 0);
    add_row(1, 0, 'hFFFFFF, 0, 0, 0, 0, 0, 0, 1, ClsUnknown, 0);
    add_row(1, 9, 0, 0, 0, 0, 0, 0, 0, 1, ClsUnknown, 9);
    add_row(1, 10, 0, 0, 0, 0, 0, 0, 0, 1, ClsHom, 10);
    add_row(1, 'hFFFFFF, 0, 0, 0, 0, 0, 0, 0, 1, ClsHom, 'hFFFFFF);
    add_row(2, 100, 100, 7, 7, 7, 7, 7, 7, 1, ClsHet, 200);
    add_row(3, 300, 300, 300, 0, 0, 0, 0, 0, 1, ClsTri, 900);
    add_row(8, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF,
            'hFFFFFF, 1, ClsNoisy, 134217720);
    add_row(15, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF,
            'hFFFFFF, 1, ClsNoisy, 134217720);
    add_row(3, 100, 400, 100, 0, 0, 0, 0, 0, 0, ClsUnknown, 0);
    add_row(3, 100, 100, 200, 0, 0, 0, 0, 0, 0, ClsUnknown, 0);
    add_row(4, 80, 160, 320, 80, 0, 0, 0, 0, 0, ClsUnknown, 0);
    add_row(5, 30, 30, 60, 240, 120, 0, 0, 0, 0, ClsUnknown, 0);
    add_row(5, 480, 30, 60, 240, 30, 0, 0, 0, 0, ClsUnknown, 0);
    // tolerance: a het split inside the tolerance, then the same with one count moved
    add_row(2, 35045, 30491, 0, 0, 0, 0, 0, 0, 0, ClsUnknown, 0);
    add_row(2, 35046, 30490, 0, 0, 0, 0, 0, 0, 0, ClsUnknown, 0);
    add_row(6, 10, 20, 30, 40, 50, 60, 0, 0, 0, ClsUnknown, 0);
    add_row(7, 1, 2, 3, 4, 5, 6, 7, 0, 0, ClsUnknown, 0);
    add_row(4, 0, 0, 50, 0, 0, 0, 0, 0, 0, ClsUnknown, 0);
    add_row(12, 0, 0, 0, 0, 0, 0, 0, 0, 1, ClsUnknown, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send(dir_rows[i].bub, dir_rows[i].typed, dir_rows[i].want);
    @(posedge clk);
    in_ch.valid <= 1'b0;
    drain();
    random_phase(150);
    drain();

    write_reg(RegMinTotal, 0);
    write_reg(RegTol, 0);
    add_row(3, 0, 0, 0, 9, 9, 9, 9, 9, 1, ClsUnknown, 0);
    send(dir_rows[$].bub, 1'b1, dir_rows[$].want);
    random_phase(130);
    drain();

    write_reg(RegMinTotal, 134217727);
    write_reg(RegTol, 65535);
    random_phase(60);
    drain();

    write_reg(RegMinTotal, 1);
    write_reg(RegTol, 65535);
    random_phase(60);
    drain();

    write_reg(RegMinTotal, $urandom_range(0, 200));
    write_reg(RegTol, $urandom_range(1000, 8000));
    random_phase(200);
    drain();

    $display("run: %0d bubbles sent, %0d beats checked, %0d failures", n_sent, n_seen, n_fail);
    $display("classes: unk=%0d hom=%0d het=%0d tri=%0d br=%0d br2=%0d noisy=%0d",
             cls_hist[0], cls_hist[1], cls_hist[2], cls_hist[3], cls_hist[4],
             cls_hist[5], cls_hist[6]);
    if (n_fail == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
